@@ rtl/core/prc_pkg.sv @@
`default_nettype none

package prc_pkg;

    // Widths of the request and result fields.
    localparam int CourseW = 7;
    localparam int KindW   = 2;
    localparam int NumW    = 8;

    // Default size of the reachability matrix, in courses.
    localparam int MaxCoursesDef = 128;

    // Value of the course count register after reset.
    localparam logic [NumW-1:0] NumCoursesRst = 8'd128;

    // Request kinds. The fourth code is ignored and answers zero.
    localparam logic [KindW-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KindW-1:0] KIND_ADD   = 2'd1;
    localparam logic [KindW-1:0] KIND_QUERY = 2'd2;

    // Controls broadcast from the sequencer to every cell of the ring.
    typedef struct packed {
        logic shift;
        logic update;
        logic clear;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/core/prc_cell.sv @@
`default_nettype none

module prc_cell
    import prc_pkg::*;
#(
    parameter int MAX_COURSES = MaxCoursesDef,
    parameter int POS         = 0
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_cell_ctl                      i_ctl,
    input  wire logic [$clog2(MAX_COURSES)-1:0] i_tag,
    input  wire logic [MAX_COURSES-1:0]         i_row,
    input  wire logic [$clog2(MAX_COURSES)-1:0] i_dep_tag,
    input  wire logic [MAX_COURSES-1:0]         i_dep_mask,
    input  wire logic [MAX_COURSES-1:0]         i_snap,
    output logic      [$clog2(MAX_COURSES)-1:0] o_tag,
    output logic      [MAX_COURSES-1:0]         o_row
);

    localparam int TW = $clog2(MAX_COURSES);

    logic [TW-1:0]          r_tag;
    logic [TW-1:0]          n_tag;
    logic [MAX_COURSES-1:0] r_row;
    logic [MAX_COURSES-1:0] n_row;
    logic                   w_hit;

    // A row takes the snapshot when it is the dependent course itself or
    // already reaches it.
    assign w_hit = (r_tag == i_dep_tag) || (|(r_row & i_dep_mask));

    always_comb begin
        n_tag = r_tag;
        n_row = r_row;
        if (i_ctl.clear) begin
            n_row = '0;
        end else if (i_ctl.shift) begin
            n_tag = i_tag;
            n_row = i_row;
        end else if (i_ctl.update && w_hit) begin
            n_row = r_row | i_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= TW'(POS);
            r_row <= '0;
        end else begin
            r_tag <= n_tag;
            r_row <= n_row;
        end
    end

    assign o_tag = r_tag;
    assign o_row = r_row;

endmodule

`default_nettype wire

@@ rtl/core/prc_ctrl.sv @@
`default_nettype none

module prc_ctrl
    import prc_pkg::*;
#(
    parameter int MAX_COURSES = MaxCoursesDef
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_req_valid,
    input  wire logic [KindW-1:0]               i_kind,
    input  wire logic [CourseW-1:0]             i_first,
    input  wire logic [CourseW-1:0]             i_second,
    input  wire logic [NumW-1:0]                i_num_courses,
    input  wire logic [$clog2(MAX_COURSES)-1:0] i_head_tag,
    input  wire logic [MAX_COURSES-1:0]         i_head_row,
    input  wire logic                           i_out_free,
    output logic                                o_req_ready,
    output t_cell_ctl                           o_ctl,
    output logic      [$clog2(MAX_COURSES)-1:0] o_dep_tag,
    output logic      [MAX_COURSES-1:0]         o_dep_mask,
    output logic      [MAX_COURSES-1:0]         o_snap,
    output logic                                o_res_load,
    output logic                                o_answer,
    output logic                                o_status
);

    localparam int TW = $clog2(MAX_COURSES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SEEK  = 4'b0010,
        S_APPLY = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [KindW-1:0]       r_kind;
    logic [TW-1:0]          r_pre;
    logic [TW-1:0]          r_dep;
    logic                   r_answer;
    logic                   n_answer;
    logic                   r_status;
    logic                   n_status;
    logic [MAX_COURSES-1:0] r_snap;
    logic [MAX_COURSES-1:0] n_snap;

    logic                   w_accept;
    logic                   w_first_ok;
    logic                   w_second_ok;
    logic                   w_edge_kind;
    logic [CourseW+TW-1:0]  w_first_ext;
    logic [CourseW+TW-1:0]  w_second_ext;
    logic [TW-1:0]          w_target;
    logic                   w_found;
    logic [MAX_COURSES-1:0] w_pre_mask;

    assign w_accept     = i_req_valid && (r_state == S_IDLE);
    assign w_first_ext  = {{TW{1'b0}}, i_first};
    assign w_second_ext = {{TW{1'b0}}, i_second};

    // An index is usable when it is below both the course count and the matrix size.
    assign w_first_ok  = ({1'b0, i_first} < i_num_courses)
                      && ({25'd0, i_first} < 32'(MAX_COURSES));
    assign w_second_ok = ({1'b0, i_second} < i_num_courses)
                      && ({25'd0, i_second} < 32'(MAX_COURSES));
    assign w_edge_kind = (i_kind == KIND_ADD) || (i_kind == KIND_QUERY);

    // An add looks for the prerequisite's row, a query for the dependent's row.
    assign w_target   = (r_kind == KIND_ADD) ? r_pre : r_dep;
    assign w_found    = (i_head_tag == w_target);
    assign w_pre_mask = {{(MAX_COURSES-1){1'b0}}, 1'b1} << r_pre;

    always_comb begin
        n_state      = r_state;
        n_answer     = r_answer;
        n_status     = r_status;
        n_snap       = r_snap;
        o_ctl        = '0;
        o_res_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_answer = 1'b0;
                    n_status = w_edge_kind && !(w_first_ok && w_second_ok);
                    o_ctl.clear = (i_kind == KIND_CLEAR);
                    if (w_edge_kind && w_first_ok && w_second_ok) begin
                        n_state = S_SEEK;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SEEK: begin
                if (w_found) begin
                    if (r_kind == KIND_QUERY) begin
                        n_answer = |(i_head_row & w_pre_mask);
                        n_state  = S_FIN;
                    end else begin
                        n_snap  = i_head_row | w_pre_mask;
                        n_state = S_APPLY;
                    end
                end else begin
                    o_ctl.shift = 1'b1;
                end
            end
            S_APPLY: begin
                o_ctl.update = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_answer <= 1'b0;
            r_status <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_answer <= n_answer;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap <= n_snap;
        if (w_accept) begin
            r_kind <= i_kind;
            r_pre  <= w_first_ext[TW-1:0];
            r_dep  <= w_second_ext[TW-1:0];
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_dep_tag   = r_dep;
    assign o_dep_mask  = {{(MAX_COURSES-1){1'b0}}, 1'b1} << r_dep;
    assign o_snap      = r_snap;
    assign o_answer    = r_answer;
    assign o_status    = r_status;

`ifndef SYNTHESIS
    a_apply_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |=> (r_state == S_FIN))
        else $error("update sweep did not finish in one cycle");

    a_clear_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.clear |=> (r_state == S_FIN && r_status == 1'b0 && r_answer == 1'b0))
        else $error("clear request did not complete with a clean result");

    a_seek_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEEK) |-> (r_kind == KIND_ADD || r_kind == KIND_QUERY))
        else $error("ring rotation started for a request that needs none");

    a_flag_no_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status |-> !r_answer)
        else $error("flagged request carries an answer");
`endif

endmodule

`default_nettype wire

@@ rtl/core/prerequisite_reachability_closure_unit.sv @@
`default_nettype none

// Reachability closure over up to MAX_COURSES courses. Row c of the matrix marks
// every course that is a direct or indirect prerequisite of course c. The rows
// live in a ring of cells that rotate one place per cycle while a request seeks
// its row; each cell carries its row number along. A query rotates the ring until
// the dependent's row reaches the head and reads one bit; an add rotates until the
// prerequisite's row reaches the head, takes a snapshot, then updates every row
// in parallel. The ring is never rotated back, so the cost of a request is the
// distance from the head to the row it needs; a clear, an ignored kind or a
// flagged index needs no rotation.
// One request is processed at a time; the next is accepted as soon as the
// previous result sits in the output register. The course count register may
// only be written while the block is idle.
module prerequisite_reachability_closure_unit
    import prc_pkg::*;
#(
    parameter int MAX_COURSES = MaxCoursesDef
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_wen,
    input  wire logic [NumW-1:0] i_cfg_wdata,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire logic [15:0]     i_s_axis_tdata,  // first_course[6:0], second_course[13:7]
    input  wire logic [1:0]      i_s_axis_tuser,  // kind[1:0]
    output logic                 o_m_axis_tvalid,
    input  wire logic            i_m_axis_tready,
    output logic      [7:0]      o_m_axis_tdata,  // answer[0]
    output logic      [0:0]      o_m_axis_tuser   // status[0]
);

    localparam int TW = $clog2(MAX_COURSES);

    logic [NumW-1:0]        r_num_courses;
    logic                   r_out_valid;
    logic                   r_out_answer;
    logic                   r_out_status;

    t_cell_ctl              w_ctl;
    logic [TW-1:0]          w_dep_tag;
    logic [MAX_COURSES-1:0] w_dep_mask;
    logic [MAX_COURSES-1:0] w_snap;
    logic                   w_out_free;
    logic                   w_res_load;
    logic                   w_answer;
    logic                   w_status;
    logic [TW-1:0]          w_tag [MAX_COURSES];
    logic [MAX_COURSES-1:0] w_row [MAX_COURSES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_courses <= NumCoursesRst;
        end else if (i_cfg_wen) begin
            r_num_courses <= i_cfg_wdata;
        end
    end

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    prc_ctrl #(
        .MAX_COURSES(MAX_COURSES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_axis_tvalid),
        .i_kind        (i_s_axis_tuser),
        .i_first       (i_s_axis_tdata[6:0]),
        .i_second      (i_s_axis_tdata[13:7]),
        .i_num_courses (r_num_courses),
        .i_head_tag    (w_tag[0]),
        .i_head_row    (w_row[0]),
        .i_out_free    (w_out_free),
        .o_req_ready   (o_s_axis_tready),
        .o_ctl         (w_ctl),
        .o_dep_tag     (w_dep_tag),
        .o_dep_mask    (w_dep_mask),
        .o_snap        (w_snap),
        .o_res_load    (w_res_load),
        .o_answer      (w_answer),
        .o_status      (w_status)
    );

    // Each cell takes its neighbor's row on a shift; the last cell takes the head's row.
    for (genvar k = 0; k < MAX_COURSES; k++) begin : g_ring
        localparam int NEXT = (k + 1) % MAX_COURSES;
        prc_cell #(
            .MAX_COURSES(MAX_COURSES),
            .POS        (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_tag      (w_tag[NEXT]),
            .i_row      (w_row[NEXT]),
            .i_dep_tag  (w_dep_tag),
            .i_dep_mask (w_dep_mask),
            .i_snap     (w_snap),
            .o_tag      (w_tag[k]),
            .o_row      (w_row[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_answer <= w_answer;
            r_out_status <= w_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_answer};
    assign o_m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire
